@@ hw/rtl/gedu_pkg.sv @@
// Shared beat types and header constants for the gzip extra header detector.
`default_nettype none

package gedu_pkg;

  // Header layout.
  localparam int unsigned HdrLen = 24;
  localparam int unsigned PosW   = 5;

  // Input beat: one byte of the buffer plus the end-of-buffer mark.
  typedef struct packed {
    logic [7:0] byte_in;
    logic       last;
  } gedu_in_t;

  // Result beat: detection flag and the two sizes from the extra field.
  typedef struct packed {
    logic        detected;
    logic [31:0] source_size;
    logic [31:0] destination_size;
  } gedu_out_t;

endpackage : gedu_pkg

`default_nettype wire

@@ hw/rtl/gedu_parse.sv @@
// Header parser: byte position, mismatch flag, size accumulators and result logic.
`default_nettype none

module gedu_parse
  import gedu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      beat_valid_i,
  input  gedu_in_t  beat_i,
  output logic      res_valid_o,
  output gedu_out_t res_o
);

  // Expected byte values of the fixed header fields.
  localparam logic [7:0] GzId1     = 8'd31;
  localparam logic [7:0] GzId2     = 8'd139;
  localparam logic [7:0] CmDeflate = 8'd8;
  localparam logic [7:0] FlgExtra  = 8'h04;
  localparam logic [7:0] XLen      = 8'd12;
  localparam logic [7:0] SubId1    = 8'h51;
  localparam logic [7:0] SubId2    = 8'h5A;
  localparam logic [7:0] SubLen    = 8'd8;
  localparam logic [PosW-1:0] LastPos = PosW'(HdrLen - 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic            mismatch_q, mismatch_d;
  logic [31:0]     src_q, src_d;
  logic [31:0]     dst_q, dst_d;
  logic            given_q, given_d;

  logic            byte_ok;
  logic [31:0]     lane_word;

  // Check the current byte against its header position.
  always_comb begin
    byte_ok = 1'b1;
    case (pos_q)
      5'd0:    byte_ok = (beat_i.byte_in == GzId1);
      5'd1:    byte_ok = (beat_i.byte_in == GzId2);
      5'd2:    byte_ok = (beat_i.byte_in == CmDeflate);
      5'd3:    byte_ok = ((beat_i.byte_in & FlgExtra) != 8'd0);
      5'd10:   byte_ok = (beat_i.byte_in == XLen);
      5'd11:   byte_ok = (beat_i.byte_in == 8'd0);
      5'd12:   byte_ok = (beat_i.byte_in == SubId1);
      5'd13:   byte_ok = (beat_i.byte_in == SubId2);
      5'd14:   byte_ok = (beat_i.byte_in == SubLen);
      5'd15:   byte_ok = (beat_i.byte_in == 8'd0);
      default: byte_ok = 1'b1;
    endcase
  end

  // Place the byte in its little-endian lane of a 32-bit word.
  assign lane_word = {24'd0, beat_i.byte_in} << {pos_q[1:0], 3'b000};

  // Next state and result for one beat.
  always_comb begin
    pos_d       = pos_q;
    mismatch_d  = mismatch_q;
    src_d       = src_q;
    dst_d       = dst_q;
    given_d     = given_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (beat_valid_i) begin
      if (given_q) begin
        // Trailing bytes are dropped; the final one closes the buffer, so the next byte starts a new one.
        if (beat_i.last) begin
          pos_d      = '0;
          mismatch_d = 1'b0;
          src_d      = '0;
          dst_d      = '0;
          given_d    = 1'b0;
        end
      end else begin
        mismatch_d = mismatch_q | ~byte_ok;
        if (pos_q[4:2] == 3'b100) begin
          src_d = src_q | lane_word;
        end else if (pos_q[4:2] == 3'b101) begin
          dst_d = dst_q | lane_word;
        end
        if (pos_q >= LastPos) begin
          res_valid_o = 1'b1;
          res_o.detected = ~mismatch_d;
          res_o.source_size = mismatch_d ? 32'd0 : src_d;
          res_o.destination_size = mismatch_d ? 32'd0 : dst_d;
          if (beat_i.last) begin
            pos_d      = '0;
            mismatch_d = 1'b0;
            src_d      = '0;
            dst_d      = '0;
          end else begin
            given_d = 1'b1;
          end
        end else if (beat_i.last) begin
          // Buffer ended before the header was complete.
          res_valid_o = 1'b1;
          res_o       = '0;
          pos_d       = '0;
          mismatch_d  = 1'b0;
          src_d       = '0;
          dst_d       = '0;
        end else begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      mismatch_q <= 1'b0;
      src_q      <= '0;
      dst_q      <= '0;
      given_q    <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      mismatch_q <= mismatch_d;
      src_q      <= src_d;
      dst_q      <= dst_d;
      given_q    <= given_d;
    end
  end

endmodule : gedu_parse

`default_nettype wire

@@ hw/rtl/gzip_extra_header_detector_unit.sv @@
// Top level of the gzip extra header detector: input register, parser, result register.
// A result passes from the input register through the parser into the result register before it appears on out_valid_o.
// Throughput: one input beat per cycle, limited only by out_stall_i backpressure.
// The parser state advances once per beat through one short compare-and-merge stage.
// Reset (rst_ni low, asynchronous) clears both registers' valid flags and the parser
// position, mismatch flag and size accumulators; the next beat starts a new buffer.
`default_nettype none

module gzip_extra_header_detector_unit
  import gedu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  gedu_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output gedu_out_t out_data_o
);

  logic      in_valid_q;
  gedu_in_t  in_data_q;
  logic      out_valid_q;
  gedu_out_t out_data_q;
  logic      advance;
  logic      res_valid;
  gedu_out_t res;

  // The held beat moves on whenever the result register can take a new beat.
  assign advance    = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = in_valid_q & ~advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  // Header parser.
  gedu_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_valid_i(in_valid_q & advance),
    .beat_i      (in_data_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q & res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule : gzip_extra_header_detector_unit

`default_nettype wire

@@ verif/gzip_extra_header_detector_unit_tb.sv @@
// Self-checking testbench for the gzip extra header detector unit.
`timescale 1ns / 100ps

module gzip_extra_header_detector_unit_tb;
  import gedu_pkg::*;

  // Header byte values that the detector compares against.
  localparam logic [7:0] ID1        = 8'd31;
  localparam logic [7:0] ID2        = 8'd139;
  localparam logic [7:0] CM_DEFLATE = 8'd8;
  localparam logic [7:0] FEXTRA     = 8'h04;
  localparam logic [7:0] XLEN_QZ    = 8'd12;
  localparam logic [7:0] SUB_ID1    = 8'h51;  // 'Q'
  localparam logic [7:0] SUB_ID2    = 8'h5A;  // 'Z'
  localparam logic [7:0] SUB_LEN    = 8'd8;

  localparam int unsigned RANDOM_BEATS     = 1000;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned FILL_BEATS       = 40;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned SHOW_FAILS       = 10;

  // A valid header: unchecked bits at extremes, source size all ones, destination zero.
  localparam logic [7:0] GOOD_HDR [HdrLen] = '{
    ID1, ID2, CM_DEFLATE, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
    XLEN_QZ, 8'h00, SUB_ID1, SUB_ID2, SUB_LEN, 8'h00,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    gedu_in_t  beat;
    logic      typed;
    gedu_out_t want;
  } dir_row_t;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  gedu_in_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  gedu_out_t out_data;

  gzip_extra_header_detector_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // Mirror of the parser state.
  logic [PosW-1:0] hdr_pos  = '0;
  logic            hdr_bad  = 1'b0;
  logic [31:0]     src_acc  = '0;
  logic [31:0]     dst_acc  = '0;
  logic            hdr_done = 1'b0;

  gedu_out_t   header_reports_q [$];
  int unsigned beats_sent      = 0;
  int unsigned buffers_closed  = 0;
  int unsigned results_checked = 0;
  int unsigned headers_found   = 0;
  int unsigned fail_count      = 0;
  int unsigned burst_left      = 0;

  // Receiver side controls.
  logic        long_hold_req = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned phase_left    = 0;
  int unsigned stall_mode    = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("** gzip_extra_header_detector_unit: FAILED **");
    $finish;
  end

  task automatic clear_header_state();
    hdr_pos  = '0;
    hdr_bad  = 1'b0;
    src_acc  = '0;
    dst_acc  = '0;
    hdr_done = 1'b0;
  endtask

  function automatic logic header_byte_ok(input logic [PosW-1:0] pos, input logic [7:0] v);
    case (pos)
      5'd0:    return v == ID1;
      5'd1:    return v == ID2;
      5'd2:    return v == CM_DEFLATE;
      5'd3:    return (v & FEXTRA) != 8'h00;
      5'd10:   return v == XLEN_QZ;
      5'd11:   return v == 8'h00;
      5'd12:   return v == SUB_ID1;
      5'd13:   return v == SUB_ID2;
      5'd14:   return v == SUB_LEN;
      5'd15:   return v == 8'h00;
      default: return 1'b1;
    endcase
  endfunction

  // Advances the mirrored parser by one byte and reports whether a result is due.
  task automatic predict_header_step(input gedu_in_t beat, output logic got,
                                     output gedu_out_t res);
    got = 1'b0;
    res = '0;
    // Bytes past the header are dropped until the buffer ends.
    if (hdr_done) begin
      if (beat.last) clear_header_state();
      return;
    end
    if (!header_byte_ok(hdr_pos, beat.byte_in)) hdr_bad = 1'b1;
    if (hdr_pos >= 16 && hdr_pos < 20)
      src_acc |= 32'(beat.byte_in) << (8 * (hdr_pos - 16));
    else if (hdr_pos >= 20 && hdr_pos < HdrLen)
      dst_acc |= 32'(beat.byte_in) << (8 * (hdr_pos - 20));
    // The last header byte always yields the verdict.
    if (hdr_pos >= HdrLen - 1) begin
      got                  = 1'b1;
      res.detected         = !hdr_bad;
      res.source_size      = hdr_bad ? 32'd0 : src_acc;
      res.destination_size = hdr_bad ? 32'd0 : dst_acc;
      if (beat.last) clear_header_state();
      else hdr_done = 1'b1;
      return;
    end
    // A buffer that ends early is reported as not detected.
    if (beat.last) begin
      got = 1'b1;
      clear_header_state();
      return;
    end
    hdr_pos = hdr_pos + 5'd1;
  endtask

  // Offers one beat, waits for it to be taken, records the expectation, then paces the sender.
  task automatic send_beat(input gedu_in_t beat, input logic typed = 1'b0,
                           input gedu_out_t want = '0);
    logic        got;
    gedu_out_t   res;
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk_i); while (in_stall);
    predict_header_step(beat, got, res);
    if (got) header_reports_q.push_back(typed ? want : res);
    beats_sent++;
    if (beat.last) buffers_closed++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Stops offering beats until every pending result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    wait (header_reports_q.size() == 0);
    @(posedge clk_i);
  endtask

  // Receiver stall pattern, with a single long hold-off on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          phase_left = $urandom_range(8, 60);
        end
        phase_left--;
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  gedu_out_t want_res;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      results_checked++;
      if (out_data.detected) headers_found++;
      if (header_reports_q.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_FAILS)
          $display("%0t: result with nothing expected: det=%0b src=%h dst=%h", $realtime,
                   out_data.detected, out_data.source_size, out_data.destination_size);
      end else begin
        want_res = header_reports_q.pop_front();
        if (out_data.detected !== want_res.detected ||
            out_data.source_size !== want_res.source_size ||
            out_data.destination_size !== want_res.destination_size) begin
          fail_count++;
          if (fail_count <= SHOW_FAILS)
            $display("%0t: mismatch: expected det=%0b src=%h dst=%h, got det=%0b src=%h dst=%h",
                     $realtime, want_res.detected, want_res.source_size,
                     want_res.destination_size, out_data.detected, out_data.source_size,
                     out_data.destination_size);
        end
      end
    end
  end

  // Stimulus.
  initial begin
    dir_row_t    dir_tab [$];
    dir_row_t    row;
    gedu_in_t    beat;
    logic [7:0]  hdr [HdrLen + 8];
    int unsigned rnd_beats;
    int unsigned len;
    int unsigned pos;
    int unsigned pick;
    logic        fill_done;

    rnd_beats = 0;
    fill_done = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: a one-byte buffer, then a full header ending on its last byte.
    row.beat.byte_in = 8'hFF;
    row.beat.last    = 1'b1;
    row.typed        = 1'b1;
    row.want         = '0;
    dir_tab.push_back(row);
    for (int i = 0; i < HdrLen; i++) begin
      row.beat.byte_in = GOOD_HDR[i];
      row.beat.last    = (i == HdrLen - 1);
      row.typed        = row.beat.last;
      row.want         = '{detected: 1'b1, source_size: 32'hFFFF_FFFF,
                           destination_size: 32'h0000_0000};
      dir_tab.push_back(row);
    end
    foreach (dir_tab[i]) send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);
    drain_results();

    // Random buffers, mostly well-formed headers with random content.
    while (rnd_beats < RANDOM_BEATS) begin
      // Halfway through, let the receiver hold off while one-byte buffers pile up.
      if (!fill_done && rnd_beats >= RANDOM_BEATS / 2) begin
        fill_done     = 1'b1;
        long_hold_req = 1'b1;
        for (int k = 0; k < FILL_BEATS; k++) begin
          beat.byte_in = 8'($urandom);
          beat.last    = 1'b1;
          send_beat(beat);
          rnd_beats++;
        end
        drain_results();
      end

      if ($urandom_range(0, 3) != 0) begin
        for (int i = 0; i < HdrLen; i++) hdr[i] = GOOD_HDR[i];
        hdr[3] = 8'($urandom) | FEXTRA;
        for (int i = 4; i < 10; i++) hdr[i] = 8'($urandom);
        pick = $urandom_range(0, 9);
        for (int i = 16; i < HdrLen; i++)
          hdr[i] = (pick == 0) ? 8'hFF : (pick == 1) ? 8'h00 : 8'($urandom);
        for (int i = HdrLen; i < HdrLen + 8; i++) hdr[i] = 8'($urandom);
        // Now and then break one checked byte.
        if ($urandom_range(0, 9) < 3) begin
          pos = $urandom_range(0, 9);
          if (pos >= 4) pos = pos + 6;
          if (pos == 3) hdr[3] = hdr[3] & ~FEXTRA;
          else hdr[pos] = hdr[pos] ^ 8'($urandom_range(1, 255));
        end
        pick = $urandom_range(0, 9);
        if (pick < 2) len = $urandom_range(1, HdrLen - 1);
        else if (pick < 5) len = HdrLen;
        else len = HdrLen + $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          beat.byte_in = hdr[i];
          beat.last    = (i == len - 1);
          send_beat(beat);
          rnd_beats++;
        end
      end else begin
        // Noise, sometimes with a stray end mark or none at all.
        len = $urandom_range(1, 30);
        for (int i = 0; i < len; i++) begin
          beat.byte_in = 8'($urandom);
          beat.last    = (i == len - 1) ? ($urandom_range(0, 4) != 0)
                                        : ($urandom_range(0, 15) == 0);
          send_beat(beat);
          rnd_beats++;
        end
      end
    end

    in_valid <= 1'b0;
    wait (header_reports_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes in %0d buffers (directed header, random headers, noise).",
             beats_sent, buffers_closed);
    $display("Checked %0d results, %0d with the extended header found.",
             results_checked, headers_found);
    if (fail_count == 0 && header_reports_q.size() == 0) begin
      $display("** gzip_extra_header_detector_unit: PASSED **");
    end else begin
      $display("%0d failures, %0d results still expected.", fail_count,
               header_reports_q.size());
      $display("** gzip_extra_header_detector_unit: FAILED **");
    end
    $finish;
  end

endmodule
